[rtl/great_circle_distance_core_assert.svh]
// Assertion macros used by the checker module of this block.
`ifndef GREAT_CIRCLE_DISTANCE_CORE_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GCD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/gcd_pkg.sv]
package gcd_pkg;

	// Default build options.
	localparam int CORDIC_STEPS_DEF    = 32;
	localparam int ANGLE_FRAC_BITS_DEF = 23;

	// Working format: signed, 56 fraction bits. Inputs carry 23 fraction bits.
	localparam int WF      = 56;
	localparam int IN_FRAC = 23;

	typedef logic signed [63:0] word_t;

	localparam logic [63:0] PI_Q62      = 64'hC90FDAA22168C235;
	localparam logic [63:0] PI_W        = (PI_Q62 + 64'd32) >> 6;
	localparam logic [63:0] ONE_W       = 64'd1 << WF;
	localparam logic [63:0] RPD_FULL    = PI_Q62 / 64'd180;
	localparam logic [56:0] RAD_PER_DEG = RPD_FULL[56:0];

	// Angle reduction limits in input degrees.
	localparam logic [32:0] FULL_DEG    = 33'd360 << IN_FRAC;
	localparam logic [32:0] HALF_DEG    = 33'd180 << IN_FRAC;
	localparam logic [32:0] QUARTER_DEG = 33'd90 << IN_FRAC;

	// Restoring division, used only while building constants.
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		int b;
		q = '0;
		r = '0;
		for (b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// floor(num * 2^bits / d), low 64 bits of the quotient.
	function automatic logic [63:0] frac_div(logic [63:0] num, int bits, logic [63:0] d);
		logic [127:0] q;
		logic [127:0] r;
		int n;
		q = '0;
		r = {64'd0, num};
		for (n = 0; n < bits; n++) begin
			r = r << 1;
			q = q << 1;
			if (r >= {64'd0, d}) begin
				r = r - {64'd0, d};
				q[0] = 1'b1;
			end
		end
		return q[63:0];
	endfunction

	// atan(2^-i) in the working format, from a Taylor series in Q62.
	function automatic logic [63:0] atan_q56(int i);
		logic [63:0] acc;
		logic [63:0] term;
		int k;
		int e;
		acc = '0;
		if (i == 0) begin
			acc = PI_Q62 >> 2;
		end else begin
			for (k = 0; i * (2 * k + 1) <= 62; k++) begin
				e = i * (2 * k + 1);
				term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
				acc = (k % 2 == 1) ? acc - term : acc + term;
			end
		end
		return (acc + 64'd32) >> 6;
	endfunction

	// Largest gain compensation K with K*K*P <= 1 for the given step count.
	function automatic logic [63:0] cordic_k(int steps);
		logic [127:0] p;
		logic [127:0] kv;
		logic [127:0] c;
		logic [127:0] sq;
		logic [127:0] pr;
		int i;
		int b;
		p = 128'd1 << WF;
		kv = '0;
		for (i = 0; i < steps; i++) begin
			if (2 * i < 64)
				p = p + (p >> (2 * i));
		end
		for (b = WF - 1; b >= 0; b--) begin
			c = kv | (128'd1 << b);
			sq = (c * c) >> WF;
			pr = (sq * p) >> WF;
			if (pr <= (128'd1 << WF))
				kv = c;
		end
		return kv[63:0];
	endfunction

	// Millimetres per radian with 18 fraction bits.
	function automatic logic [63:0] mm_per_rad_calc();
		logic [63:0] r;
		logic [127:0] prod;
		logic [63:0] t;
		r = frac_div(64'd180, 116, PI_Q62 >> 2);
		prod = {64'd0, r} * 128'd1111948742964;
		t = prod[101:38];
		return t / 64'd10000;
	endfunction

	localparam logic [63:0] MM_FULL    = mm_per_rad_calc();
	localparam logic [50:0] MM_PER_RAD = MM_FULL[50:0];

endpackage

[rtl/gcd_cos.sv]
module gcd_cos #(
	parameter int STEPS = gcd_pkg::CORDIC_STEPS_DEF,
	parameter int AFB   = gcd_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [32:0]   angle,
	output logic                 out_valid,
	output gcd_pkg::word_t       cos_out
);

	localparam logic [63:0] K_FULL = gcd_pkg::cordic_k(STEPS);
	localparam int          LAT    = STEPS + 6;

	logic [LAT:1] vld_s;

	logic [32:0] mag_s1;
	logic [31:0] mod_s2;
	logic [29:0] ang_s3;
	logic        neg_s3;
	logic [58:0] plo_s4;
	logic [57:0] phi_s4;
	logic        neg_s4;

	gcd_pkg::word_t rx_s [0:STEPS];
	gcd_pkg::word_t ry_s [0:STEPS];
	gcd_pkg::word_t rz_s [0:STEPS];
	logic [STEPS:0] rneg_s;

	logic [31:0] fold_a;
	logic [31:0] fold_b;
	logic        fold_neg;
	logic [87:0] pfull;

	// Valid bits move with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], in_valid};
		end
	end

	// Fold the reduced angle into the first quadrant.
	always_comb begin
		fold_a = (mod_s2 > gcd_pkg::HALF_DEG[31:0]) ?
			gcd_pkg::FULL_DEG[31:0] - mod_s2 : mod_s2;
		fold_neg = fold_a > gcd_pkg::QUARTER_DEG[31:0];
		fold_b = fold_neg ? gcd_pkg::HALF_DEG[31:0] - fold_a : fold_a;
	end

	assign pfull = {1'b0, phi_s4, 29'd0} + {29'd0, plo_s4};

	// Magnitude, reduction modulo a full turn, fold, and conversion to radians.
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= angle[32] ? 33'(-angle) : 33'(angle);
			mod_s2 <= (mag_s1 >= gcd_pkg::FULL_DEG) ?
				32'(mag_s1 - gcd_pkg::FULL_DEG) : mag_s1[31:0];
			ang_s3 <= 30'(fold_b >> (gcd_pkg::IN_FRAC - AFB));
			neg_s3 <= fold_neg;
			plo_s4 <= 59'(ang_s3) * 59'(gcd_pkg::RAD_PER_DEG[28:0]);
			phi_s4 <= 58'(ang_s3) * 58'(gcd_pkg::RAD_PER_DEG[56:29]);
			neg_s4 <= neg_s3;
			rx_s[0] <= signed'(K_FULL);
			ry_s[0] <= '0;
			rz_s[0] <= signed'(64'(pfull >> (AFB + 6)));
			rneg_s[0] <= neg_s4;
		end
	end

	// Rotation steps, one per register stage.
	for (genvar gi = 0; gi < STEPS; gi++) begin : g_rot
		localparam logic [63:0] ATAN = gcd_pkg::atan_q56(gi);
		always_ff @(posedge clk) begin
			if (en) begin
				if (rz_s[gi] >= 0) begin
					rx_s[gi+1] <= rx_s[gi] - (ry_s[gi] >>> gi);
					ry_s[gi+1] <= ry_s[gi] + (rx_s[gi] >>> gi);
					rz_s[gi+1] <= rz_s[gi] - signed'(ATAN);
				end else begin
					rx_s[gi+1] <= rx_s[gi] + (ry_s[gi] >>> gi);
					ry_s[gi+1] <= ry_s[gi] - (rx_s[gi] >>> gi);
					rz_s[gi+1] <= rz_s[gi] + signed'(ATAN);
				end
				rneg_s[gi+1] <= rneg_s[gi];
			end
		end
	end

	// Apply the quadrant sign.
	always_ff @(posedge clk) begin
		if (en) begin
			cos_out <= rneg_s[STEPS] ? -rx_s[STEPS] : rx_s[STEPS];
		end
	end

	assign out_valid = vld_s[LAT];

endmodule

[rtl/gcd_acos.sv]
module gcd_acos #(
	parameter int STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  gcd_pkg::word_t s_in,
	output logic           out_valid,
	output logic [57:0]    angle
);

	localparam int ROOT_BITS = 57;
	localparam int LAT       = STEPS + ROOT_BITS + 5;

	logic [LAT:1] vld_s;

	logic [56:0] m_s1, m_s2, m_s3;
	logic        neg_s1, neg_s2, neg_s3;
	logic [55:0] hh_s2;
	logic [56:0] hl_s2;
	logic [57:0] ll_s2;
	logic [56:0] sqh_s3;

	logic [113:0] op_s  [0:ROOT_BITS];
	logic [113:0] res_s [0:ROOT_BITS];
	logic [56:0]  sm_s  [0:ROOT_BITS];
	logic [ROOT_BITS:0] sneg_s;

	gcd_pkg::word_t vx_s [1:STEPS];
	gcd_pkg::word_t vy_s [1:STEPS];
	gcd_pkg::word_t vz_s [1:STEPS];
	logic [STEPS:1] vneg_s;

	logic [114:0] sq_full;
	logic [56:0]  t_val;
	gcd_pkg::word_t zf;
	gcd_pkg::word_t zc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], in_valid};
		end
	end

	assign sq_full = 115'({hh_s2, ll_s2}) + 115'({hl_s2, 30'd0});
	assign t_val   = gcd_pkg::ONE_W[56:0] - sqh_s3;

	// Magnitude, its square in partial products, and 1 - m*m.
	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= s_in[63] ? 57'(-s_in) : 57'(s_in);
			neg_s1 <= s_in[63];
			hh_s2 <= 56'(m_s1[56:29]) * 56'(m_s1[56:29]);
			hl_s2 <= 57'(m_s1[56:29]) * 57'(m_s1[28:0]);
			ll_s2 <= 58'(m_s1[28:0]) * 58'(m_s1[28:0]);
			m_s2 <= m_s1;
			neg_s2 <= neg_s1;
			sqh_s3 <= 57'(sq_full >> gcd_pkg::WF);
			m_s3 <= m_s2;
			neg_s3 <= neg_s2;
			op_s[0] <= {1'b0, t_val, 56'd0};
			res_s[0] <= '0;
			sm_s[0] <= m_s3;
			sneg_s[0] <= neg_s3;
		end
	end

	// Square root, one result bit per stage, most significant first.
	for (genvar gj = 0; gj < ROOT_BITS; gj++) begin : g_root
		localparam logic [113:0] ONE_BIT = 114'd1 << (2 * (ROOT_BITS - 1 - gj));
		logic [113:0] trial;
		assign trial = res_s[gj] + ONE_BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (op_s[gj] >= trial) begin
					op_s[gj+1] <= op_s[gj] - trial;
					res_s[gj+1] <= (res_s[gj] + (ONE_BIT << 1)) >> 1;
				end else begin
					op_s[gj+1] <= op_s[gj];
					res_s[gj+1] <= res_s[gj] >> 1;
				end
				sm_s[gj+1] <= sm_s[gj];
				sneg_s[gj+1] <= sneg_s[gj];
			end
		end
	end

	// Vectoring steps that drive y to zero and collect the angle.
	for (genvar gi = 0; gi < STEPS; gi++) begin : g_vec
		localparam logic [63:0] ATAN = gcd_pkg::atan_q56(gi);
		gcd_pkg::word_t xi, yi, zi;
		logic ni;
		if (gi == 0) begin : g_first
			assign xi = signed'({7'd0, sm_s[ROOT_BITS]});
			assign yi = signed'({7'd0, res_s[ROOT_BITS][56:0]});
			assign zi = '0;
			assign ni = sneg_s[ROOT_BITS];
		end else begin : g_rest
			assign xi = vx_s[gi];
			assign yi = vy_s[gi];
			assign zi = vz_s[gi];
			assign ni = vneg_s[gi];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (yi >= 0) begin
					vx_s[gi+1] <= xi + (yi >>> gi);
					vy_s[gi+1] <= yi - (xi >>> gi);
					vz_s[gi+1] <= zi + signed'(ATAN);
				end else begin
					vx_s[gi+1] <= xi - (yi >>> gi);
					vy_s[gi+1] <= yi + (xi >>> gi);
					vz_s[gi+1] <= zi - signed'(ATAN);
				end
				vneg_s[gi+1] <= ni;
			end
		end
	end

	// Mirror for negative input and keep the angle within [0, pi].
	always_comb begin
		zf = vneg_s[STEPS] ? signed'(gcd_pkg::PI_W) - vz_s[STEPS] : vz_s[STEPS];
		if (zf < 0)
			zc = '0;
		else if (zf > signed'(gcd_pkg::PI_W))
			zc = signed'(gcd_pkg::PI_W);
		else
			zc = zf;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle <= zc[57:0];
		end
	end

	assign out_valid = vld_s[LAT];

endmodule

[rtl/great_circle_distance_core.sv]
// Great-circle distance by the spherical law of cosines. Each input transfer
// carries two points (latitude and longitude, signed degrees with 23 fraction
// bits) and yields one output transfer with the distance in millimetres,
// rounded to nearest. One pair is accepted every clock cycle while s_tready
// is high. From an input transfer to the output register, an item passes
// through the three parallel cosine rotation pipelines, the 57-stage
// bit-per-stage square root, and the arc-cosine vectoring pipeline. The
// output register is backed by one skid entry, so s_tready drops only after
// a result has been put in the skid entry while the output was stalled.
// No state is kept between items.
module great_circle_distance_core #(
	parameter int CORDIC_STEPS    = gcd_pkg::CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// lat_start[30:0], lon_start[62:31], lat_end[93:63], lon_end[125:94], zero fill
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// distance_mm[34:0], zero fill
	output logic [39:0]  m_tdata
);

	logic en;

	logic signed [30:0] lat_start, lat_end;
	logic signed [31:0] lon_start, lon_end;

	logic               v_s1;
	logic signed [32:0] slat_s1, dlat_s1, dlon_s1;

	logic [2:0]     cos_v;
	gcd_pkg::word_t cos_p, cos_m, cos_l;

	logic [7:1]         mv_s;
	logic signed [64:0] sum_s1m, dif_s1m, dif_s2m, dif_s3m, dif_s4m, dif_s5m;
	gcd_pkg::word_t     cl_s1m;
	logic [57:0]        amag_s2m;
	logic [56:0]        bmag_s2m;
	logic               sgn_s2m, sgn_s3m, sgn_s4m, sgn_s5m;
	logic [56:0]        hh_s3m, x1_s3m;
	logic [57:0]        ll_s3m, x2_s3m;
	logic [114:0]       base_s4m;
	logic [58:0]        cross_s4m;
	logic [115:0]       prod_m;
	logic [59:0]        r_s5m;
	logic signed [65:0] v_s6m;
	logic signed [65:0] half_m;
	gcd_pkg::word_t     s_s7m;

	logic        acos_v;
	logic [57:0] ang;

	logic [4:1]   fv_s;
	logic [54:0]  hh_s1f, x1_s1f;
	logic [53:0]  ll_s1f, x2_s1f;
	logic [108:0] base_s2f;
	logic [83:0]  cross_s2f;
	logic [109:0] tot_f;
	logic [36:0]  q_s3f;
	logic [34:0]  mm_s4f;
	logic [36:0]  q_inc;

	logic        out_v_q, skid_v_q;
	logic [34:0] out_d_q, skid_d_q;
	logic        take;
	logic        out_free;

	localparam logic signed [65:0] POS_ONE = 66'sd1 <<< gcd_pkg::WF;
	localparam logic signed [65:0] NEG_ONE = -POS_ONE;

	// The pipeline advances while the skid entry is free.
	assign en       = !skid_v_q;
	assign s_tready = en;

	assign lat_start = s_tdata[30:0];
	assign lon_start = s_tdata[62:31];
	assign lat_end   = s_tdata[93:63];
	assign lon_end   = s_tdata[125:94];

	// Angle sums and differences.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			slat_s1 <= 33'(lat_start) + 33'(lat_end);
			dlat_s1 <= 33'(lat_start) - 33'(lat_end);
			dlon_s1 <= 33'(lon_end) - 33'(lon_start);
		end
	end

	gcd_cos #(.STEPS(CORDIC_STEPS), .AFB(ANGLE_FRAC_BITS)) u_cos_p (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.angle(slat_s1), .out_valid(cos_v[0]), .cos_out(cos_p)
	);

	gcd_cos #(.STEPS(CORDIC_STEPS), .AFB(ANGLE_FRAC_BITS)) u_cos_m (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.angle(dlat_s1), .out_valid(cos_v[1]), .cos_out(cos_m)
	);

	gcd_cos #(.STEPS(CORDIC_STEPS), .AFB(ANGLE_FRAC_BITS)) u_cos_l (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.angle(dlon_s1), .out_valid(cos_v[2]), .cos_out(cos_l)
	);

	// Combine the cosines into s, with the wide product in partial products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s <= '0;
		end else if (en) begin
			mv_s <= {mv_s[6:1], &cos_v};
		end
	end

	assign prod_m = 116'(base_s4m) + 116'({cross_s4m, 29'd0});
	assign half_m = v_s6m >>> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1m <= {cos_m[63], cos_m} + {cos_p[63], cos_p};
			dif_s1m <= {cos_m[63], cos_m} - {cos_p[63], cos_p};
			cl_s1m <= cos_l;
			amag_s2m <= sum_s1m[64] ? 58'(-sum_s1m) : 58'(sum_s1m);
			bmag_s2m <= cl_s1m[63] ? 57'(-cl_s1m) : 57'(cl_s1m);
			sgn_s2m <= sum_s1m[64] ^ cl_s1m[63];
			dif_s2m <= dif_s1m;
			hh_s3m <= 57'(amag_s2m[57:29]) * 57'(bmag_s2m[56:29]);
			ll_s3m <= 58'(amag_s2m[28:0]) * 58'(bmag_s2m[28:0]);
			x1_s3m <= 57'(amag_s2m[28:0]) * 57'(bmag_s2m[56:29]);
			x2_s3m <= 58'(amag_s2m[57:29]) * 58'(bmag_s2m[28:0]);
			sgn_s3m <= sgn_s2m;
			dif_s3m <= dif_s2m;
			base_s4m <= {hh_s3m, ll_s3m};
			cross_s4m <= 59'(x1_s3m) + 59'(x2_s3m);
			sgn_s4m <= sgn_s3m;
			dif_s4m <= dif_s3m;
			r_s5m <= 60'(prod_m >> gcd_pkg::WF);
			sgn_s5m <= sgn_s4m;
			dif_s5m <= dif_s4m;
			v_s6m <= sgn_s5m ? {dif_s5m[64], dif_s5m} - signed'({6'd0, r_s5m}) :
				{dif_s5m[64], dif_s5m} + signed'({6'd0, r_s5m});
			if (half_m > POS_ONE)
				s_s7m <= POS_ONE[63:0];
			else if (half_m < NEG_ONE)
				s_s7m <= NEG_ONE[63:0];
			else
				s_s7m <= half_m[63:0];
		end
	end

	gcd_acos #(.STEPS(CORDIC_STEPS)) u_acos (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(mv_s[7]),
		.s_in(s_s7m), .out_valid(acos_v), .angle(ang)
	);

	// Scale the angle to millimetres and round half up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_s <= '0;
		end else if (en) begin
			fv_s <= {fv_s[3:1], acos_v};
		end
	end

	assign tot_f = 110'(base_s2f) + 110'(cross_s2f);
	assign q_inc = q_s3f + 37'd1;

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1f <= 55'(ang[57:29]) * 55'(gcd_pkg::MM_PER_RAD[50:25]);
			ll_s1f <= 54'(ang[28:0]) * 54'(gcd_pkg::MM_PER_RAD[24:0]);
			x1_s1f <= 55'(ang[28:0]) * 55'(gcd_pkg::MM_PER_RAD[50:25]);
			x2_s1f <= 54'(ang[57:29]) * 54'(gcd_pkg::MM_PER_RAD[24:0]);
			base_s2f <= {hh_s1f, ll_s1f};
			cross_s2f <= 84'({x1_s1f, 25'd0}) + 84'({x2_s1f, 29'd0});
			q_s3f <= 37'(tot_f >> (gcd_pkg::WF + 17));
			mm_s4f <= q_inc[35:1];
		end
	end

	// Output register with one skid entry behind it.
	assign take     = fv_s[4] && en;
	assign out_free = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= skid_v_q || take;
			skid_v_q <= 1'b0;
		end else if (take) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_d_q <= skid_v_q ? skid_d_q : mm_s4f;
		end else if (take) begin
			skid_d_q <= mm_s4f;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'd0, out_d_q};

endmodule

[rtl/gcd_checker.sv]
`include "great_circle_distance_core_assert.svh"

module gcd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// A held output transfer keeps its data.
	`GCD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")

	// The padding above the distance stays zero.
	`GCD_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[39:35] == 5'd0, "output padding not zero")

	// No distance exceeds 20100000000 mm, a bound just above half the circumference.
	`GCD_ASSERT_NOW(a_range, m_tvalid, m_tdata[34:0] <= 35'd20100000000, "distance out of range")

	// With the output empty the skid entry is empty and input is taken.
	`GCD_ASSERT_NOW(a_ready_idle, !m_tvalid, s_tready, "input stalled with output empty")

	// Input only stalls after the output side held a result back.
	`GCD_ASSERT_NOW(a_ready_drop, $fell(s_tready) && s_tvalid, $past(m_tvalid && !m_tready), "input stalled without output stall")

endmodule

bind great_circle_distance_core gcd_checker u_gcd_checker (.*);
